// ===== rtl/ikm_pkg.sv =====
package ikm_pkg;

  localparam int TICK_W      = 32;
  localparam int KEY_W       = 5;
  localparam int OP_W        = 3;
  localparam int STAT_W      = 2;
  localparam int ENTRIES_DEF = 64;

  localparam logic [TICK_W-1:0] TICK_LIMIT = '1;
  localparam logic [TICK_W-1:0] TICK_CLAMP = {{(TICK_W-1){1'b1}}, 1'b0};

  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_CHANGE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_LAST      = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  // update command broadcast to every cell
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_OVERWRITE,
    CMD_INSERT,
    CMD_DELETE,
    CMD_CHANGE,
    CMD_CLEAR
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    logic [TICK_W-1:0] tick;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  dflt;
  } cell_ctl_t;

  // what one cell shows its neighbors and the top level
  typedef struct packed {
    logic              valid;
    logic              above;
    logic              first;
    logic              exact;
    logic              start_eq;
    logic [TICK_W-1:0] seg_end;
    logic [TICK_W-1:0] seg_start;
    logic [KEY_W-1:0]  seg_key;
  } cell_link_t;

endpackage

// ===== rtl/ikm_cell.sv =====
module ikm_cell
  import ikm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head,
  input  logic              cap,
  input  logic [TICK_W-1:0] cap_tick,
  input  logic              upd,
  input  cell_ctl_t         ctl,
  input  cell_link_t        prv,
  input  cell_link_t        nxt,
  output cell_link_t        link
);

  logic              valid_r, valid_nxt;
  logic [TICK_W-1:0] end_r, end_nxt;
  logic [TICK_W-1:0] start_r, start_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic              above_r, exact_r, seq_r;
  logic              first;

  // sorted ends: above flags are monotonic, so first is a neighbor test
  assign first = above_r & ~prv.above;

  always_comb begin
    valid_nxt = valid_r;
    end_nxt   = end_r;
    start_nxt = start_r;
    key_nxt   = key_r;
    case (ctl.cmd)
      CMD_OVERWRITE: begin
        if (first) key_nxt = ctl.key;
      end
      CMD_CHANGE: begin
        if (exact_r) key_nxt = ctl.key;
      end
      CMD_INSERT: begin
        if (first) begin
          end_nxt = ctl.tick;
        end else if (prv.first) begin
          valid_nxt = 1'b1;
          end_nxt   = prv.seg_end;
          start_nxt = ctl.tick;
          key_nxt   = ctl.key;
        end else if (prv.above) begin
          valid_nxt = 1'b1;
          end_nxt   = prv.seg_end;
          start_nxt = prv.seg_start;
          key_nxt   = prv.seg_key;
        end
      end
      CMD_DELETE: begin
        if (exact_r) begin
          end_nxt = nxt.seg_end;
        end else if (above_r) begin
          valid_nxt = nxt.valid;
          end_nxt   = nxt.seg_end;
          start_nxt = nxt.seg_start;
          key_nxt   = nxt.seg_key;
        end
      end
      CMD_CLEAR: begin
        valid_nxt = head;
        end_nxt   = TICK_LIMIT;
        start_nxt = '0;
        key_nxt   = head ? ctl.dflt : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= head;
      end_r   <= TICK_LIMIT;
      start_r <= '0;
      key_r   <= '0;
      above_r <= 1'b0;
      exact_r <= 1'b0;
      seq_r   <= 1'b0;
    end else begin
      if (cap) begin
        above_r <= valid_r & (end_r > cap_tick);
        exact_r <= valid_r & (end_r == cap_tick);
        seq_r   <= start_r == cap_tick;
      end
      if (upd) begin
        valid_r <= valid_nxt;
        end_r   <= end_nxt;
        start_r <= start_nxt;
        key_r   <= key_nxt;
      end
    end
  end

  assign link.valid     = valid_r;
  assign link.above     = above_r;
  assign link.first     = first;
  assign link.exact     = exact_r;
  assign link.start_eq  = seq_r;
  assign link.seg_end   = end_r;
  assign link.seg_start = start_r;
  assign link.seg_key   = key_r;

endmodule

// ===== rtl/interval_key_map.sv =====
// Output: the result is registered when the update state applies the op; that
//   state waits while a previous result is still held, and it can then transfer.
// Items: none is accepted until the last is applied; the accept cycle registers a
//   tick compare in every cell, the update state applies the update along the chain.
// Reset: synchronous, active low; the table holds a single segment covering all
//   ticks below all-ones with key 0, fallback key 0. No clearing pass is needed.
module interval_key_map
  import ikm_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration: fallback key
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [KEY_W-1:0]  cfg_fallback_key,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [TICK_W-1:0] in_tick,
  input  logic [KEY_W-1:0]  in_key,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KEY_W-1:0]  out_key_out,
  output logic [STAT_W-1:0] out_status
);

  typedef enum logic {ST_IDLE, ST_UPD} state_t;

  state_t            st_r;
  logic [OP_W-1:0]   op_r;
  logic [TICK_W-1:0] tick_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  dflt_r;
  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  logic [STAT_W-1:0] out_stat_r;

  logic              cap, upd, out_free;
  logic [TICK_W-1:0] cap_tick;
  cell_ctl_t         ctl;
  cell_link_t        lnk [ENTRIES];

  // chain-wide summaries, all read from registered cell flags
  logic              any_first, ow_hit, any_exact, exact_last, full;
  logic [KEY_W-1:0]  hit_key;
  logic [KEY_W-1:0]  res_key;
  logic [STAT_W-1:0] res_stat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st_r == ST_IDLE);
  assign cap       = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;
  assign upd       = (st_r == ST_UPD) & out_free;

  // add clamps the tick so the last segment keeps its all-ones end
  assign cap_tick = (in_op == OP_ADD && (&in_tick)) ? TICK_CLAMP : in_tick;

  always_comb begin
    any_first  = 1'b0;
    ow_hit     = 1'b0;
    any_exact  = 1'b0;
    exact_last = 1'b0;
    hit_key    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      any_first = any_first | lnk[i].first;
      ow_hit    = ow_hit | (lnk[i].first & lnk[i].start_eq);
      any_exact = any_exact | lnk[i].exact;
      hit_key   = hit_key | (lnk[i].first ? lnk[i].seg_key : '0);
      if (i == ENTRIES - 1) begin
        exact_last = exact_last | lnk[i].exact;
      end else begin
        exact_last = exact_last | (lnk[i].exact & ~lnk[(i + 1) % ENTRIES].valid);
      end
    end
    full = lnk[ENTRIES-1].valid;
  end

  // decode the pending op into a cell command and a result
  always_comb begin
    ctl.cmd  = CMD_NONE;
    ctl.tick = tick_r;
    ctl.key  = key_r;
    ctl.dflt = dflt_r;
    res_key  = '0;
    res_stat = ST_OK;
    unique case (op_r)
      OP_LOOKUP: res_key = any_first ? hit_key : dflt_r;
      OP_ADD: begin
        if (!any_first)  res_stat = ST_NOT_FOUND;
        else if (ow_hit) ctl.cmd  = CMD_OVERWRITE;
        else if (full)   res_stat = ST_FULL;
        else             ctl.cmd  = CMD_INSERT;
      end
      OP_DELETE: begin
        if (!any_exact)      res_stat = ST_NOT_FOUND;
        else if (exact_last) res_stat = ST_LAST;
        else                 ctl.cmd  = CMD_DELETE;
      end
      OP_CHANGE: begin
        if (!any_exact) res_stat = ST_NOT_FOUND;
        else            ctl.cmd  = CMD_CHANGE;
      end
      OP_CLEAR: ctl.cmd = CMD_CLEAR;
      default: ;
    endcase
  end

  // the cell row: each cell sees only its two neighbors
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    cell_link_t prv, nxt;
    if (i == 0) begin : g_head
      assign prv = '0;
    end else begin : g_mid
      assign prv = lnk[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_body
      assign nxt = lnk[i+1];
    end
    ikm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .head     (i == 0),
      .cap      (cap),
      .cap_tick (cap_tick),
      .upd      (upd),
      .ctl      (ctl),
      .prv      (prv),
      .nxt      (nxt),
      .link     (lnk[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      dflt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) dflt_r <= cfg_fallback_key;
      unique case (st_r)
        ST_IDLE: begin
          if (cap) begin
            op_r   <= in_op;
            tick_r <= cap_tick;
            key_r  <= in_key;
            st_r   <= ST_UPD;
          end
          if (out_valid_r && out_ready) out_valid_r <= 1'b0;
        end
        ST_UPD: begin
          if (upd) begin
            out_valid_r <= 1'b1;
            out_key_r   <= res_key;
            out_stat_r  <= res_stat;
            st_r        <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_key_out = out_key_r;
  assign out_status  = out_stat_r;

endmodule

// ===== sim/key_map_checker.sv =====
`timescale 1ns / 100ps

module key_map_checker
  import ikm_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [KEY_W-1:0]  cfg_fallback_key,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [TICK_W-1:0] in_tick,
  input  logic [KEY_W-1:0]  in_key,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [KEY_W-1:0]  out_key_out,
  input  logic [STAT_W-1:0] out_status,
  output int                fail_count,
  output int                pending,
  output int                checked_cnt,
  output int                full_cnt,
  output int                miss_cnt,
  output int                last_cnt,
  output int                peak_fill
);

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [TICK_W-1:0] tick;
    logic [KEY_W-1:0]  key_out;
    logic [STAT_W-1:0] status;
  } answer_t;

  // shadow copy of the segment table
  logic [TICK_W-1:0] span_end   [ENTRIES];
  logic [TICK_W-1:0] span_start [ENTRIES];
  logic [KEY_W-1:0]  span_key   [ENTRIES];
  int                span_cnt;
  logic [KEY_W-1:0]  fallback_key;

  answer_t answer_q[$];
  answer_t head;
  answer_t fresh;

  initial begin
    fail_count  = 0;
    pending     = 0;
    checked_cnt = 0;
    full_cnt    = 0;
    miss_cnt    = 0;
    last_cnt    = 0;
    peak_fill   = 1;
  end

  function automatic void init_table();
    for (int i = 0; i < ENTRIES; i++) begin
      span_end[i]   = '0;
      span_start[i] = '0;
      span_key[i]   = '0;
    end
    span_end[0] = TICK_LIMIT;
    span_key[0] = fallback_key;
    span_cnt    = 1;
  endfunction

  function automatic int first_above(logic [TICK_W-1:0] t);
    for (int i = 0; i < span_cnt; i++)
      if (span_end[i] > t) return i;
    return span_cnt;
  endfunction

  function automatic int ends_at(logic [TICK_W-1:0] t);
    for (int i = 0; i < span_cnt; i++)
      if (span_end[i] == t) return i;
    return span_cnt;
  endfunction

  // apply one command to the shadow table, return the answer it yields
  task automatic apply_map_op(input logic [OP_W-1:0] op, input logic [TICK_W-1:0] tick,
                              input logic [KEY_W-1:0] key,
                              output logic [KEY_W-1:0] kout, output logic [STAT_W-1:0] st);
    logic [TICK_W-1:0] t;
    int hit;
    t    = tick;
    kout = '0;
    st   = ST_OK;
    case (op)
      OP_LOOKUP: begin
        hit  = first_above(t);
        kout = (hit < span_cnt) ? span_key[hit] : fallback_key;
      end
      OP_ADD: begin
        if (t > TICK_CLAMP) t = TICK_CLAMP;
        hit = first_above(t);
        if (hit >= span_cnt) begin
          st = ST_NOT_FOUND;
        end else if (span_start[hit] == t) begin
          span_key[hit] = key;
        end else if (span_cnt >= ENTRIES) begin
          st = ST_FULL;
        end else begin
          for (int j = span_cnt; j > hit; j--) begin
            span_end[j]   = span_end[j-1];
            span_start[j] = span_start[j-1];
            span_key[j]   = span_key[j-1];
          end
          // lower part keeps its key, upper part takes the new one
          span_end[hit]     = t;
          span_start[hit+1] = t;
          span_key[hit+1]   = key;
          span_cnt++;
        end
      end
      OP_DELETE: begin
        hit = ends_at(t);
        if (hit >= span_cnt) begin
          st = ST_NOT_FOUND;
        end else if (hit + 1 >= span_cnt) begin
          st = ST_LAST;
        end else begin
          // successor absorbs the deleted segment's start and key
          span_start[hit+1] = span_start[hit];
          span_key[hit+1]   = span_key[hit];
          for (int j = hit; j + 1 < span_cnt; j++) begin
            span_end[j]   = span_end[j+1];
            span_start[j] = span_start[j+1];
            span_key[j]   = span_key[j+1];
          end
          span_cnt--;
          span_end[span_cnt]   = '0;
          span_start[span_cnt] = '0;
          span_key[span_cnt]   = '0;
        end
      end
      OP_CHANGE: begin
        hit = ends_at(t);
        if (hit >= span_cnt) st = ST_NOT_FOUND;
        else span_key[hit] = key;
      end
      OP_CLEAR: init_table();
      default: ;
    endcase
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fallback_key = '0;
      init_table();
      answer_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          note_failure($sformatf("result key %0d status %0d with nothing outstanding",
                                 out_key_out, out_status));
        end else begin
          head = answer_q.pop_front();
          checked_cnt++;
          if (out_key_out !== head.key_out || out_status !== head.status)
            note_failure($sformatf(
                "op %0d tick %h: expected key %0d status %0d, got key %0d status %0d",
                head.op, head.tick, head.key_out, head.status, out_key_out, out_status));
        end
      end
      if (cfg_valid && cfg_ready) fallback_key = cfg_fallback_key;
      if (in_valid && in_ready) begin
        fresh.op   = in_op;
        fresh.tick = in_tick;
        apply_map_op(in_op, in_tick, in_key, fresh.key_out, fresh.status);
        answer_q.push_back(fresh);
        if (fresh.status == ST_FULL) full_cnt++;
        if (fresh.status == ST_NOT_FOUND) miss_cnt++;
        if (fresh.status == ST_LAST) last_cnt++;
        if (span_cnt > peak_fill) peak_fill = span_cnt;
      end
    end
    pending <= answer_q.size();
  end

endmodule

// ===== sim/tb_interval_key_map.sv =====
`timescale 1ns / 100ps

module tb_interval_key_map;
  import ikm_pkg::*;

  localparam int ENTRIES         = ENTRIES_DEF;
  localparam int ITEMS_PER_BLOCK = 85;
  localparam int RX_HOLD_CYCLES  = 300;  // long enough to back up the pipe
  localparam int DRAIN_SLACK     = 6;    // slack after the last answer is back
  localparam int CYCLE_LIMIT     = 200000;
  localparam int POOL_MAX        = 96;

  // traffic mixes used by the random blocks
  typedef enum int {MIX_ANY, MIX_GROW, MIX_TRIM} mix_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [KEY_W-1:0]  cfg_fallback_key = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   in_op = OP_LOOKUP;
  logic [TICK_W-1:0] in_tick = '0;
  logic [KEY_W-1:0]  in_key = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [KEY_W-1:0]  out_key_out;
  logic [STAT_W-1:0] out_status;

  // checker outputs
  int fail_count, pending, checked_cnt, full_cnt, miss_cnt, last_cnt, peak_fill;

  // stimulus knobs
  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic rx_hold      = 1'b0;
  logic hold_go      = 1'b0;
  int   cycle_cnt    = 0;
  int   items_sent   = 0;
  int   cfg_writes   = 0;

  // ticks of recent adds, so deletes and changes find real ends
  logic [TICK_W-1:0] tick_pool[$];

  // main loop scratch
  mix_t              mix;
  int                roll;
  int                pool_pct;
  logic [OP_W-1:0]   pick_op;
  logic [TICK_W-1:0] pick_tick;

  interval_key_map #(.ENTRIES(ENTRIES)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_fallback_key(cfg_fallback_key),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_tick         (in_tick),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_key_out     (out_key_out),
    .out_status      (out_status)
  );

  key_map_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_fallback_key(cfg_fallback_key),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_tick         (in_tick),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_key_out     (out_key_out),
    .out_status      (out_status),
    .fail_count      (fail_count),
    .pending         (pending),
    .checked_cnt     (checked_cnt),
    .full_cnt        (full_cnt),
    .miss_cnt        (miss_cnt),
    .last_cnt        (last_cnt),
    .peak_fill       (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the handshake locks up
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off when requested
  always @(posedge clk) begin
    out_ready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Offer one command and return at the edge where it transfers.
  // Random idle cycles go in front; valid is dropped only while idling.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [TICK_W-1:0] tick,
                           input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_tick  <= tick;
    in_key   <= key;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    // keep the tick pool in step with what the table should hold
    if (op == OP_ADD) begin
      tick_pool.push_back((tick > TICK_CLAMP) ? TICK_CLAMP : tick);
      if (tick_pool.size() > POOL_MAX) void'(tick_pool.pop_front());
    end else if (op == OP_CLEAR) begin
      tick_pool.delete();
    end
  endtask

  // Sender goes quiet until every answer is back, plus a little slack.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_fallback_key(input logic [KEY_W-1:0] value);
    cfg_valid        <= 1'b1;
    cfg_fallback_key <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: fresh table, fallback key 0 ----
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_LOOKUP, TICK_LIMIT, '1);          // beyond every end -> fallback
    send_item(OP_ADD, TICK_LIMIT, 5'd31);          // clamped to the last legal tick
    send_item(OP_LOOKUP, TICK_CLAMP, '0);
    send_item(OP_ADD, '0, 5'd5);                   // tick equals segment start: overwrite
    send_item(OP_ADD, 32'd100, 5'd7);              // split
    send_item(OP_ADD, 32'd100, 5'd9);              // overwrite of the new upper part
    send_item(OP_CHANGE, 32'd100, 5'd3);
    send_item(OP_CHANGE, 32'd12345, 5'd1);         // no segment ends there
    send_item(OP_DELETE, 32'd555, '0);             // no segment ends there
    send_item(OP_DELETE, TICK_LIMIT, '0);          // last segment stays
    send_item(OP_DELETE, 32'd100, '0);             // merge into successor
    send_item(OP_LOOKUP, 32'd50, '0);
    send_item(3'd5, TICK_LIMIT, '1);               // unused codes are ignored
    send_item(3'd6, '0, '0);
    send_item(3'd7, 32'h5555_AAAA, 5'd21);
    send_item(OP_CLEAR, '0, '0);
    send_item(OP_LOOKUP, 32'd123, '0);

    // fallback key change: lookups past the end see it at once, the table after clear
    drain_results();
    write_fallback_key(5'd31);
    send_item(OP_LOOKUP, TICK_LIMIT, '0);
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_CLEAR, '1, '1);
    send_item(OP_LOOKUP, '0, '0);

    // ---- random: four idle/stall mixes, three blocks each ----
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: write_fallback_key(5'd0);
        1: write_fallback_key(KEY_W'($urandom_range(30, 1)));
        2: write_fallback_key(5'd31);
        default: write_fallback_key(KEY_W'($urandom_range(31)));
      endcase
      tx_idle_pct  <= (ph == 1) ? 81 : (ph == 3) ? 16 : 0;
      rx_stall_pct <= (ph == 2) ? 81 : (ph == 3) ? 16 : 0;

      for (int blk = 0; blk < 3; blk++) begin
        mix = mix_t'((ph + blk) % 3);
        // long receiver hold-off while the sender keeps pushing
        if (ph == 0 && blk == 1) hold_go <= 1'b1;
        // one pause with the sender waiting for every answer
        if (ph == 2 && blk == 1) drain_results();
        if ($urandom_range(1) == 1) send_item(OP_CLEAR, $urandom(), KEY_W'($urandom_range(31)));
        pool_pct = (mix == MIX_GROW) ? 15 : 50;

        for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
          roll = $urandom_range(99);
          case (mix)
            MIX_GROW:
              pick_op = (roll < 85) ? OP_ADD : (roll < 93) ? OP_LOOKUP : OP_CHANGE;
            MIX_TRIM:
              pick_op = (roll < 45) ? OP_DELETE : (roll < 65) ? OP_CHANGE :
                        (roll < 85) ? OP_LOOKUP : OP_ADD;
            default: begin
              if      (roll < 30) pick_op = OP_LOOKUP;
              else if (roll < 55) pick_op = OP_ADD;
              else if (roll < 72) pick_op = OP_DELETE;
              else if (roll < 88) pick_op = OP_CHANGE;
              else if (roll < 90) pick_op = OP_CLEAR;
              else if (roll < 93) pick_op = OP_W'($urandom_range(7, 5));
              else                pick_op = OP_LOOKUP;
            end
          endcase

          // ticks: known ends (and their neighbors), a crowded low range,
          // the axis extremes, or anything at all
          roll = $urandom_range(99);
          if (tick_pool.size() > 0 && roll < pool_pct) begin
            pick_tick = tick_pool[$urandom_range(tick_pool.size() - 1)];
            case ($urandom_range(3))
              0: pick_tick = pick_tick + 1;
              1: pick_tick = pick_tick - 1;
              default: ;
            endcase
          end else if (roll < pool_pct + 15) begin
            pick_tick = $urandom_range(255);
          end else if (roll < pool_pct + 23) begin
            case ($urandom_range(4))
              0: pick_tick = '0;
              1: pick_tick = 32'd1;
              2: pick_tick = TICK_CLAMP;
              3: pick_tick = TICK_LIMIT;
              default: pick_tick = 32'h8000_0000;
            endcase
          end else begin
            pick_tick = $urandom();
          end

          send_item(pick_op, pick_tick, KEY_W'($urandom_range(31)));
        end
      end
    end

    drain_results();

    $display("Ran %0d commands under four idle/stall mixes, %0d answers checked",
             items_sent, checked_cnt);
    $display("%0d fallback key writes; table peaked at %0d of %0d segments", cfg_writes,
             peak_fill, ENTRIES);
    $display("Status counts: full %0d, not found %0d, last segment %0d",
             full_cnt, miss_cnt, last_cnt);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
